/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the tile map decoder.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/tmrd_pkg.sv */
// Types and constants for the tile map run-length decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tmrd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned AREA_W  = 32;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned TDATA_W = 64;

    localparam logic [WORD_W-1:0] MASK_RESET = 16'h8000;
    localparam logic [LEN_W-1:0]  FULL_RUN   = 9'd256;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_TILE   = 1'b1;

    // command from the parser to the executing side
    typedef struct packed {
        logic              is_hdr;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
        logic [AREA_W-1:0] area;
        logic [WORD_W-1:0] tile;
        logic [LEN_W-1:0]  want;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
        logic [WORD_W-1:0] tile;
        logic [LEN_W-1:0]  len;
        logic              last;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/tmrd_front.sv */
// Byte parser: assembles header and tile words and issues run commands.
// Depends on tmrd_pkg.
`timescale 1ns / 1ps

module tmrd_front
    import tmrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              map_start,
    input  logic [WORD_W-1:0] run_flag_mask,
    output logic              push,
    output cmd_t              cmd
);

    typedef enum logic [2:0] {
        PH_W_LO,
        PH_W_HI,
        PH_H_LO,
        PH_H_HI,
        PH_TILE_LO,
        PH_TILE_HI,
        PH_COUNT
    } phase_t;

    phase_t            phase_reg, phase_next, phase_eff;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [WORD_W-1:0] width_reg, width_next;
    logic [WORD_W-1:0] pending_reg, pending_next;
    logic [WORD_W-1:0] word;

    assign word      = {data_byte, hold_reg};
    assign phase_eff = map_start ? PH_W_LO : phase_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        hold_next    = hold_reg;
        width_next   = width_reg;
        pending_next = pending_reg;
        push         = 1'b0;
        cmd.is_hdr   = 1'b0;
        cmd.width    = width_reg;
        cmd.height   = word;
        cmd.area     = {16'd0, width_reg} * {16'd0, word};
        cmd.tile     = word;
        cmd.want     = 9'd1;
        if (fire)
        begin
            case (phase_eff)
                PH_W_LO:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_W_HI;
                end
                PH_W_HI:
                begin
                    width_next = word;
                    phase_next = PH_H_LO;
                end
                PH_H_LO:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_H_HI;
                end
                PH_H_HI:
                begin
                    push       = 1'b1;
                    cmd.is_hdr = 1'b1;
                    phase_next = PH_TILE_LO;
                end
                PH_TILE_LO:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_TILE_HI;
                end
                PH_TILE_HI:
                begin
                    if ((word & run_flag_mask) == run_flag_mask)
                    begin
                        pending_next = word & ~run_flag_mask;
                        phase_next   = PH_COUNT;
                    end
                    else
                    begin
                        push       = 1'b1;
                        phase_next = PH_TILE_LO;
                    end
                end
                PH_COUNT:
                begin
                    push       = 1'b1;
                    cmd.tile   = pending_reg;
                    cmd.want   = (data_byte == '0) ? FULL_RUN : {1'b0, data_byte};
                    phase_next = PH_TILE_LO;
                end
                default:
                begin
                    phase_next = PH_W_LO;
                end
            endcase
        end
    end

    // past the map end the back side drops tile commands, so no done phase here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_W_LO;
            hold_reg    <= '0;
            width_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            width_reg   <= width_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* rtl/tmrd_queue.sv */
// Small command queue between parser and executing side.
// Depends on tmrd_pkg.
`timescale 1ns / 1ps

module tmrd_queue
    import tmrd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      wr_cmd,
    input  logic      pop,
    output cmd_t      rd_cmd,
    output q_status_t status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign rd_cmd       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/tmrd_back.sv */
// Executing side: tracks tiles left in the map, truncates runs, holds the
// output register. Depends on tmrd_pkg.
`timescale 1ns / 1ps

module tmrd_back
    import tmrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t cmd,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    logic [AREA_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] width_reg, width_next;
    logic [WORD_W-1:0] height_reg, height_next;
    logic              valid_reg, valid_next;
    res_t              res_reg, res_next;
    logic [LEN_W-1:0]  len;
    logic [AREA_W-1:0] remain;

    assign pop       = !q_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign res       = res_reg;

    assign len    = ({23'd0, cmd.want} < left_reg) ? cmd.want : left_reg[LEN_W-1:0];
    assign remain = left_reg - {23'd0, len};

    always_comb
    begin
        left_next   = left_reg;
        width_next  = width_reg;
        height_next = height_reg;
        res_next    = res_reg;
        valid_next  = valid_reg && !out_ready;
        if (pop)
        begin
            if (cmd.is_hdr)
            begin
                left_next       = cmd.area;
                width_next      = cmd.width;
                height_next     = cmd.height;
                valid_next      = 1'b1;
                res_next.kind   = KIND_HEADER;
                res_next.width  = cmd.width;
                res_next.height = cmd.height;
                res_next.tile   = '0;
                res_next.len    = '0;
                res_next.last   = (cmd.area == '0);
            end
            else if (left_reg != '0)
            begin
                // nothing left means the map is done: the tile is dropped
                left_next       = remain;
                valid_next      = 1'b1;
                res_next.kind   = KIND_TILE;
                res_next.width  = width_reg;
                res_next.height = height_reg;
                res_next.tile   = cmd.tile;
                res_next.len    = len;
                res_next.last   = (remain == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

/* rtl/tile_map_rle_decoder.sv */
// Tile map run-length decoder: one byte accepted per cycle while the queue is not full.
// A completed command is written into the queue at the edge that accepts its last byte;
// the run unit then pops it and loads the output register, unless an output stall holds it.
// Throughput is set by the single-byte parser; the queue absorbs output stalls.
// Reset: asynchronous, active low; parser expects a header, map marked done,
// run_flag_mask returns to 0x8000.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tile_map_rle_decoder
    import tmrd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WORD_W-1:0]  cfg_wdata,     // run_flag_mask
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,  // data_byte
    input  logic               s_axis_tuser,  // map_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // map_width [15:0], map_height [31:16], tile_value [47:32], run_length [56:48]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,  // result_kind
    output logic               m_axis_tlast   // last_of_map
);

    logic [WORD_W-1:0] mask_reg;
    logic              in_fire;
    logic              push;
    logic              pop;
    cmd_t              wr_cmd;
    cmd_t              rd_cmd;
    q_status_t         q_status;
    res_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MASK_RESET;
        else if (cfg_we)
            mask_reg <= cfg_wdata;
    end

    assign s_axis_tready = !q_status.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    tmrd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (in_fire),
        .data_byte     (s_axis_tdata),
        .map_start     (s_axis_tuser),
        .run_flag_mask (mask_reg),
        .push          (push),
        .cmd           (wr_cmd)
    );

    tmrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .status (q_status)
    );

    tmrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_status.empty),
        .cmd       (rd_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {7'd0, res.len, res.tile, res.height, res.width};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    `ASSERT_ALWAYS(a_queue_state, !(q_status.full && q_status.empty), "queue full and empty")
    `ASSERT_IMPLIES(a_tile_len, m_axis_tvalid && (res.kind == KIND_TILE), (res.len != '0) && (res.len <= FULL_RUN), "tile run length out of range")
    `ASSERT_IMPLIES(a_hdr_fields, m_axis_tvalid && (res.kind == KIND_HEADER), (res.len == '0) && (res.tile == '0), "header carries tile fields")
    `ASSERT_NEXT(a_push_lands, push, !q_status.empty, "pushed command not in queue")

endmodule

/* test/tb_tile_map_rle_decoder.sv */
// Testbench for tile_map_rle_decoder: byte stream in, header and tile run items out.
// Holds its own decoder predictor; depends only on tmrd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_tile_map_rle_decoder;
    import tmrd_pkg::*;

    localparam int unsigned RANDOM_BYTES  = 950;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned QUIET_LIMIT   = 2000;

    typedef enum logic [2:0]
    {
        PH_WIDTH_LO,
        PH_WIDTH_HI,
        PH_HEIGHT_LO,
        PH_HEIGHT_HI,
        PH_TILE_LO,
        PH_TILE_HI,
        PH_COUNT,
        PH_DONE
    } parse_phase_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [WORD_W-1:0]  cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    // decoder state as predicted
    logic [WORD_W-1:0]  pred_mask;
    parse_phase_t       pred_phase;
    logic [BYTE_W-1:0]  pred_low;
    logic [WORD_W-1:0]  pred_pending;
    logic [WORD_W-1:0]  pred_width;
    logic [WORD_W-1:0]  pred_height;
    logic [AREA_W-1:0]  pred_tiles_left;

    res_t        records_due[$];
    int unsigned bytes_decoded;
    int unsigned errors;
    int unsigned burst_left;
    int unsigned quiet_cycles;
    int unsigned rx_cycle;
    int unsigned rx_mode;

    tile_map_rle_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void emit_tile_run(logic [WORD_W-1:0] tile, logic [LEN_W-1:0] want);
        res_t              r;
        logic [AREA_W-1:0] len;
        len = (AREA_W'(want) < pred_tiles_left) ? AREA_W'(want) : pred_tiles_left;
        pred_tiles_left = pred_tiles_left - len;
        pred_phase = (pred_tiles_left == 0) ? PH_DONE : PH_TILE_LO;
        r.kind   = KIND_TILE;
        r.width  = pred_width;
        r.height = pred_height;
        r.tile   = tile;
        r.len    = len[LEN_W-1:0];
        r.last   = (pred_tiles_left == 0);
        records_due.push_back(r);
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic start);
        logic [WORD_W-1:0] word;
        res_t              r;
        if (start)
            pred_phase = PH_WIDTH_LO;
        if (pred_phase != PH_DONE)
            bytes_decoded++;
        case (pred_phase)
            PH_WIDTH_LO, PH_HEIGHT_LO:
            begin
                pred_low   = b;
                pred_phase = parse_phase_t'(pred_phase + 3'd1);
            end
            PH_WIDTH_HI:
            begin
                pred_width = {b, pred_low};
                pred_phase = PH_HEIGHT_LO;
            end
            PH_HEIGHT_HI:
            begin
                pred_height     = {b, pred_low};
                pred_tiles_left = AREA_W'(pred_width) * AREA_W'(pred_height);
                pred_phase      = (pred_tiles_left == 0) ? PH_DONE : PH_TILE_LO;
                r.kind   = KIND_HEADER;
                r.width  = pred_width;
                r.height = pred_height;
                r.tile   = '0;
                r.len    = '0;
                r.last   = (pred_tiles_left == 0);
                records_due.push_back(r);
            end
            PH_TILE_LO:
            begin
                pred_low   = b;
                pred_phase = PH_TILE_HI;
            end
            PH_TILE_HI:
            begin
                word = {b, pred_low};
                if ((word & pred_mask) == pred_mask)
                begin
                    pred_pending = word & ~pred_mask;
                    pred_phase   = PH_COUNT;
                end
                else
                begin
                    emit_tile_run(word, 9'd1);
                end
            end
            PH_COUNT:
                emit_tile_run(pred_pending, (b == 0) ? FULL_RUN : {1'b0, b});
            default:
                ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (records_due.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual tdata %0h kind %0b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = records_due.pop_front();
                compare_field("result_kind", WORD_W'(want.kind), WORD_W'(m_axis_tuser));
                compare_field("map_width", want.width, m_axis_tdata[15:0]);
                compare_field("map_height", want.height, m_axis_tdata[31:16]);
                compare_field("tile_value", want.tile, m_axis_tdata[47:32]);
                compare_field("run_length", WORD_W'(want.len), WORD_W'(m_axis_tdata[56:48]));
                compare_field("last_of_map", WORD_W'(want.last), WORD_W'(m_axis_tlast));
            end
        end
    end

    // receiver stall pattern; rx_cycle sets when a new mode is picked at random
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rx_cycle % 8) < 3;
            default: m_axis_tready <= (rx_cycle % 16) == 0;
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tile_map_rle_decoder test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(logic [BYTE_W-1:0] b, logic start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b, start);
    endtask

    task automatic send_word(logic [WORD_W-1:0] w);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], 1'b0);
    endtask

    task automatic send_header(logic [WORD_W-1:0] w, logic [WORD_W-1:0] h, logic start);
        send_byte(w[7:0], start);
        send_byte(w[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(h[15:8], 1'b0);
    endtask

    // hold the sender until every result is out, then let the block settle
    task automatic drain_and_hold();
        s_axis_tvalid <= 1'b0;
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_run_flag_mask(logic [WORD_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_mask = m;
    endtask

    function automatic logic [WORD_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return MASK_RESET;
            3:       return 16'hC000;
            4:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_map();
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] word;
        int unsigned       sel;
        int unsigned       words_left;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            w = 16'($urandom);
            h = '0;
            if ($urandom_range(0, 1))
            begin
                h = w;
                w = '0;
            end
        end
        else if (sel == 1)
        begin
            w = 16'($urandom);
            h = 16'($urandom);
        end
        else if (sel < 4)
        begin
            w = 16'($urandom_range(16, 48));
            h = 16'($urandom_range(4, 24));
        end
        else
        begin
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 6));
        end
        // header cut short by a restart
        if ($urandom_range(0, 19) == 0)
        begin
            send_byte(8'($urandom), 1'b1);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
        end
        send_header(w, h, 1'b1);
        words_left = $urandom_range(20, 120);
        while (pred_phase != PH_DONE && words_left > 0)
        begin
            words_left--;
            if ($urandom_range(0, 29) == 0)
            begin
                drain_and_hold();
                set_run_flag_mask(pick_mask());
            end
            // abandon the map half way through a tile word
            if ($urandom_range(0, 49) == 0)
            begin
                send_byte(8'($urandom), 1'b0);
                return;
            end
            if ($urandom_range(0, 1))
            begin
                word = 16'($urandom) | pred_mask;
            end
            else
            begin
                word = 16'($urandom);
                if ((word & pred_mask) == pred_mask && pred_mask != 0)
                    word = word & ~(pred_mask & (~pred_mask + 16'd1));
            end
            send_word(word);
            if ((word & pred_mask) == pred_mask)
                send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'b0);
        end
        if (pred_phase == PH_DONE && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_stream_after_reset();
        // no map_start: phase after reset takes a header anyway
        send_header(16'd2, 16'd1, 1'b0);
        send_word(16'h7FFF);
        send_word(16'hFFFF);
        send_byte(8'h00, 1'b0);   // count 0 is 256, truncated to the last tile
    endtask

    task automatic test_ignore_after_end();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_restart_and_empty_map();
        send_header(16'hFFFF, 16'hFFFF, 1'b1);
        send_byte(8'h34, 1'b0);
        send_header(16'h0000, 16'hFFFF, 1'b1);
    endtask

    task automatic test_mask_extremes();
        drain_and_hold();
        set_run_flag_mask(16'h0000);
        send_header(16'd1, 16'd3, 1'b1);
        send_word(16'h0000);
        send_byte(8'h02, 1'b0);
        // change mid-map
        drain_and_hold();
        set_run_flag_mask(16'hFFFF);
        send_word(16'hFFFF);
        send_byte(8'h05, 1'b0);
    endtask

    task automatic test_random_maps();
        int unsigned maps;
        maps = 0;
        bytes_decoded = 0;
        while (bytes_decoded < RANDOM_BYTES)
        begin
            if (maps % 6 == 0)
            begin
                drain_and_hold();
                set_run_flag_mask(pick_mask());
            end
            send_map();
            maps++;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        pred_mask       = MASK_RESET;
        pred_phase      = PH_WIDTH_LO;
        pred_low        = '0;
        pred_pending    = '0;
        pred_width      = '0;
        pred_height     = '0;
        pred_tiles_left = '0;
        bytes_decoded   = 0;
        errors          = 0;
        burst_left      = 0;
        quiet_cycles    = 0;
        rx_cycle        = 0;
        rx_mode         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_stream_after_reset();
        test_ignore_after_end();
        test_restart_and_empty_map();
        test_mask_extremes();
        test_random_maps();

        s_axis_tvalid <= 1'b0;
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tile_map_rle_decoder test passed");
        else
            $display("tile_map_rle_decoder test failed");
        $finish;
    end

endmodule
